[hdl/gstb_pkg.sv]
// gstb_pkg: shared types and constants of the gradient stop table baker
// used by gstb_front, gstb_back and the top level; no dependencies
package gstb_pkg;

  localparam int MAX_STOPS = 16;
  localparam int STOP_AW   = $clog2(MAX_STOPS);
  localparam int CNT_W     = $clog2(MAX_STOPS + 1);

  localparam int POS_W   = 9;
  localparam int COLOR_W = 32;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 8;
  localparam int STOP_W  = POS_W + COLOR_W;

  // span lengths and offsets reach 512 in wrap mode
  localparam int SPAN_W = POS_W + 1;
  localparam int NUM_W  = CHAN_W + SPAN_W;
  localparam int DIV_CW = $clog2(NUM_W);

  localparam logic [POS_W-1:0]   POS_ONE      = 9'd256;
  localparam logic [SPAN_W-1:0]  SPAN_ONE     = 10'd256;
  localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [POS_W-1:0]     pos;
    logic [COLOR_W-1:0]   color;
    logic [IDX_W-1:0]     idx;
  } cmd_t;

endpackage

[hdl/gstb_ram.sv]
// gstb_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
module gstb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/gstb_front.sv]
// gstb_front: accepts input transactions, decodes the action and queues
// commands for the back end in a two-entry queue; uses gstb_pkg
module gstb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [gstb_pkg::POS_W-1:0]   in_stop_position,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_red,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_green,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_blue,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_alpha,
  input  logic [gstb_pkg::IDX_W-1:0]   in_entry_index,
  output logic                         cmd_valid,
  output gstb_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);

  gstb_pkg::cmd_t q_r [2];
  logic [1:0]     fill_r, fill_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;

  gstb_pkg::cmd_t new_cmd;
  logic           known;
  logic           push;

  // decode and saturate the position
  always_comb begin
    new_cmd.pos   = (in_stop_position > gstb_pkg::POS_ONE) ? gstb_pkg::POS_ONE
                                                           : in_stop_position;
    new_cmd.color = {in_stop_red, in_stop_green, in_stop_blue, in_stop_alpha};
    new_cmd.idx   = in_entry_index;
    new_cmd.kind  = gstb_pkg::CMD_CLEAR;
    known         = 1'b1;
    unique case (in_action)
      gstb_pkg::ACT_CLEAR:  new_cmd.kind = gstb_pkg::CMD_CLEAR;
      gstb_pkg::ACT_APPEND: new_cmd.kind = gstb_pkg::CMD_APPEND;
      gstb_pkg::ACT_READ:   new_cmd.kind = gstb_pkg::CMD_READ;
      default:              known = 1'b0;
    endcase
  end

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall && known;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

[hdl/gstb_back.sv]
// gstb_back: executes queued commands against the stop memory, searches the
// stops serially and interpolates with four serial dividers; uses gstb_pkg, gstb_ram
module gstb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wrap_mode,
  input  logic                          cmd_valid,
  input  gstb_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gstb_pkg::IDX_W-1:0]    out_entry_number,
  output logic [gstb_pkg::COLOR_W-1:0]  out_color
);

  localparam int AW  = gstb_pkg::STOP_AW;
  localparam int CW  = gstb_pkg::CNT_W;
  localparam int PW  = gstb_pkg::POS_W;
  localparam int SW  = gstb_pkg::SPAN_W;
  localparam int NW  = gstb_pkg::NUM_W;
  localparam int KW  = gstb_pkg::CHAN_W;
  localparam int XW  = gstb_pkg::COLOR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RDL,
    ST_SRCH,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [gstb_pkg::IDX_W-1:0] j_r, j_nxt;
  logic [PW-1:0]          pf_r, pf_nxt, pl_r, pl_nxt, hi_pos_r, hi_pos_nxt;
  logic [XW-1:0]          cf_r, cf_nxt, cl_r, cl_nxt, hi_col_r, hi_col_nxt;
  logic [XW-1:0]          color_r, color_nxt;
  logic [SW-1:0]          n_r, n_nxt, d_r, d_nxt;
  logic [gstb_pkg::DIV_CW-1:0] div_cnt_r, div_cnt_nxt;
  logic [KW-1:0]          a_r [4], a_nxt [4];
  logic [KW-1:0]          absd_r [4], absd_nxt [4];
  logic                   neg_r [4], neg_nxt [4];
  logic [NW-1:0]          num_r [4], num_nxt [4];
  logic [SW-1:0]          rem_r [4], rem_nxt [4];
  logic                   out_valid_r, out_valid_nxt;
  logic [gstb_pkg::IDX_W-1:0] out_entry_r, out_entry_nxt;
  logic [XW-1:0]          out_color_r, out_color_nxt;

  logic                   ram_we;
  logic [gstb_pkg::STOP_W-1:0] ram_rdata;
  logic [PW-1:0]          rd_pos;
  logic [XW-1:0]          rd_color;
  logic [PW-1:0]          j9;
  logic [CW-1:0]          cnt_m1, cnt_m2;

  logic                   blend_go;
  logic [XW-1:0]          bl_ca, bl_cb;
  logic [SW-1:0]          bl_n, bl_d;
  logic [SW:0]            rem_sh [4];
  logic [KW:0]            fix_v [4];
  logic [KW-1:0]          ch_a [4], ch_b [4];

  gstb_ram #(
    .WIDTH (gstb_pkg::STOP_W),
    .DEPTH (gstb_pkg::MAX_STOPS)
  ) u_stops (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({cmd.pos, cmd.color}),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  assign rd_pos   = ram_rdata[gstb_pkg::STOP_W-1 -: PW];
  assign rd_color = ram_rdata[XW-1:0];
  assign j9       = {1'b0, j_r};
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    j_nxt         = j_r;
    pf_nxt        = pf_r;
    cf_nxt        = cf_r;
    pl_nxt        = pl_r;
    cl_nxt        = cl_r;
    hi_pos_nxt    = hi_pos_r;
    hi_col_nxt    = hi_col_r;
    color_nxt     = color_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    div_cnt_nxt   = div_cnt_r;
    out_entry_nxt = out_entry_r;
    out_color_nxt = out_color_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    blend_go      = 1'b0;
    bl_ca         = cl_r;
    bl_cb         = cf_r;
    bl_n          = '0;
    bl_d          = '0;
    for (int k = 0; k < 4; k++) begin
      a_nxt[k]    = a_r[k];
      absd_nxt[k] = absd_r[k];
      neg_nxt[k]  = neg_r[k];
      num_nxt[k]  = num_r[k];
      rem_nxt[k]  = rem_r[k];
      rem_sh[k]   = {rem_r[k], num_r[k][NW-1]};
      fix_v[k]    = '0;
      ch_a[k]     = '0;
      ch_b[k]     = '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            gstb_pkg::CMD_CLEAR: count_nxt = '0;
            gstb_pkg::CMD_APPEND: begin
              // appends beyond capacity are dropped
              if (count_r < CW'(gstb_pkg::MAX_STOPS)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            gstb_pkg::CMD_READ: begin
              j_nxt = cmd.idx;
              if (count_r == '0) begin
                color_nxt = gstb_pkg::OPAQUE_BLACK;
                state_nxt = ST_DONE;
              end else begin
                addr_nxt  = '0;
                state_nxt = ST_RD0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RD0: begin
        pf_nxt = rd_pos;
        cf_nxt = rd_color;
        if (count_r == CW'(1)) begin
          color_nxt = rd_color;
          state_nxt = ST_DONE;
        end else begin
          addr_nxt  = cnt_m1[AW-1:0];
          state_nxt = ST_RDL;
        end
      end

      ST_RDL: begin
        pl_nxt     = rd_pos;
        cl_nxt     = rd_color;
        hi_pos_nxt = rd_pos;
        hi_col_nxt = rd_color;
        if (j9 >= rd_pos) begin
          // trailing region
          if (wrap_mode) begin
            blend_go  = 1'b1;
            bl_ca     = rd_color;
            bl_cb     = cf_r;
            bl_n      = {1'b0, j9} - {1'b0, rd_pos};
            bl_d      = {1'b0, pf_r} + gstb_pkg::SPAN_ONE - {1'b0, rd_pos};
            state_nxt = ST_MUL;
          end else begin
            color_nxt = rd_color;
            state_nxt = ST_DONE;
          end
        end else begin
          addr_nxt  = cnt_m2[AW-1:0];
          state_nxt = ST_SRCH;
        end
      end

      ST_SRCH: begin
        // rd_pos/rd_color is the lower stop of the span ending at hi_pos_r
        if (rd_pos <= j9 && j9 < hi_pos_r) begin
          blend_go  = 1'b1;
          bl_ca     = rd_color;
          bl_cb     = hi_col_r;
          bl_n      = {1'b0, j9} - {1'b0, rd_pos};
          bl_d      = {1'b0, hi_pos_r} - {1'b0, rd_pos};
          state_nxt = ST_MUL;
        end else begin
          hi_pos_nxt = rd_pos;
          hi_col_nxt = rd_color;
          if (addr_r == '0) begin
            // leading region, or nothing covers the entry
            if (j9 < pf_r) begin
              if (wrap_mode) begin
                blend_go  = 1'b1;
                bl_ca     = cl_r;
                bl_cb     = cf_r;
                bl_n      = {1'b0, j9} + gstb_pkg::SPAN_ONE - {1'b0, pl_r};
                bl_d      = {1'b0, pf_r} + gstb_pkg::SPAN_ONE - {1'b0, pl_r};
                state_nxt = ST_MUL;
              end else begin
                color_nxt = cf_r;
                state_nxt = ST_DONE;
              end
            end else begin
              color_nxt = gstb_pkg::OPAQUE_BLACK;
              state_nxt = ST_DONE;
            end
          end else begin
            addr_nxt = addr_r - AW'(1);
          end
        end
      end

      ST_MUL: begin
        for (int k = 0; k < 4; k++) begin
          num_nxt[k] = NW'(absd_r[k]) * NW'(n_r);
          rem_nxt[k] = '0;
        end
        div_cnt_nxt = gstb_pkg::DIV_CW'(NW - 1);
        state_nxt   = ST_DIV;
      end

      ST_DIV: begin
        // one restoring step per cycle in each lane
        for (int k = 0; k < 4; k++) begin
          if (rem_sh[k] >= {1'b0, d_r}) begin
            rem_nxt[k] = SW'(rem_sh[k] - {1'b0, d_r});
            num_nxt[k] = {num_r[k][NW-2:0], 1'b1};
          end else begin
            rem_nxt[k] = rem_sh[k][SW-1:0];
            num_nxt[k] = {num_r[k][NW-2:0], 1'b0};
          end
        end
        if (div_cnt_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          div_cnt_nxt = div_cnt_r - gstb_pkg::DIV_CW'(1);
        end
      end

      ST_FIX: begin
        // falling channels round toward minus infinity
        for (int k = 0; k < 4; k++) begin
          if (neg_r[k]) begin
            fix_v[k] = {1'b0, a_r[k]} - {1'b0, num_r[k][KW-1:0]}
                       - (KW+1)'(rem_r[k] != '0);
          end else begin
            fix_v[k] = {1'b0, a_r[k]} + {1'b0, num_r[k][KW-1:0]};
          end
          color_nxt[XW-1-KW*k -: KW] = fix_v[k][KW-1:0];
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = j_r;
          out_color_nxt = color_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (blend_go) begin
      n_nxt = bl_n;
      d_nxt = bl_d;
      for (int k = 0; k < 4; k++) begin
        ch_a[k]     = bl_ca[XW-1-KW*k -: KW];
        ch_b[k]     = bl_cb[XW-1-KW*k -: KW];
        a_nxt[k]    = ch_a[k];
        neg_nxt[k]  = ch_b[k] < ch_a[k];
        absd_nxt[k] = (ch_b[k] < ch_a[k]) ? ch_a[k] - ch_b[k] : ch_b[k] - ch_a[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r      <= addr_nxt;
    j_r         <= j_nxt;
    pf_r        <= pf_nxt;
    cf_r        <= cf_nxt;
    pl_r        <= pl_nxt;
    cl_r        <= cl_nxt;
    hi_pos_r    <= hi_pos_nxt;
    hi_col_r    <= hi_col_nxt;
    color_r     <= color_nxt;
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_entry_r <= out_entry_nxt;
    out_color_r <= out_color_nxt;
    for (int k = 0; k < 4; k++) begin
      a_r[k]    <= a_nxt[k];
      absd_r[k] <= absd_nxt[k];
      neg_r[k]  <= neg_nxt[k];
      num_r[k]  <= num_nxt[k];
      rem_r[k]  <= rem_nxt[k];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_number = out_entry_r;
  assign out_color        = out_color_r;

endmodule

[hdl/gradient_stop_table_baker.sv]
// gradient_stop_table_baker: top level, wrap mode register and the two halves
// depends on gstb_pkg, gstb_front, gstb_back (which holds gstb_ram)
// Usage:
//   Input channel (in_valid/in_stall) carries one action per transaction:
//   clear the stop list, append a stop, or read one of 256 table entries.
//   Only reads produce a transaction on the result channel (out_valid/out_stall),
//   which echoes the entry index together with its RGBA color.
//   cfg_write_en/cfg_wrap_mode write the wrap mode bit; do it while idle.
//   A two-entry command queue sits between the decode side and the
//   execution side, so input is taken while a result waits to be drained.
// Sequence:
//   clear and append complete in the idle state of the execution side.
//   A read with no stops goes straight to the done state; otherwise it reads
//   the first stop (the result with one stop), then the last stop (the result
//   at or past it without wrap), then takes up to MAX_STOPS-1 serial search
//   steps; an interpolation adds the multiply, the 18-step serial divide and the fix-up.
//   The serial stop search and the serial divider set how long a read takes.
// Reset: the stop list is empty, wrap mode is off, both channels are idle.
// A stalled result holds in the output register; further reads wait for it
// while the queue keeps taking input until it is full.
module gradient_stop_table_baker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write_en,
  input  logic                         cfg_wrap_mode,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [gstb_pkg::POS_W-1:0]   in_stop_position,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_red,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_green,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_blue,
  input  logic [gstb_pkg::CHAN_W-1:0]  in_stop_alpha,
  input  logic [gstb_pkg::IDX_W-1:0]   in_entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gstb_pkg::IDX_W-1:0]   out_entry_number,
  output logic [gstb_pkg::CHAN_W-1:0]  out_red,
  output logic [gstb_pkg::CHAN_W-1:0]  out_green,
  output logic [gstb_pkg::CHAN_W-1:0]  out_blue,
  output logic [gstb_pkg::CHAN_W-1:0]  out_alpha
);

  logic                          wrap_r;
  logic                          cmd_valid;
  logic                          cmd_pop;
  gstb_pkg::cmd_t                cmd;
  logic [gstb_pkg::COLOR_W-1:0]  color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b0;
    end else if (cfg_write_en) begin
      wrap_r <= cfg_wrap_mode;
    end
  end

  gstb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_stop_alpha    (in_stop_alpha),
    .in_entry_index   (in_entry_index),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  gstb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wrap_mode        (wrap_r),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entry_number (out_entry_number),
    .out_color        (color)
  );

  assign out_red   = color[31:24];
  assign out_green = color[23:16];
  assign out_blue  = color[15:8];
  assign out_alpha = color[7:0];

endmodule
